FILE: hw/rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// Static linked list package
// Sizes, status and kind codes, controller commands and link reset values.
// ----------------------------------------------------------------------------
package sll_pkg;

	localparam int NODES    = 16;
	localparam int NODE_W   = $clog2(NODES);
	localparam int POS_W    = 5;
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 4;
	localparam int CMP_W    = ((POS_W > NODE_W) ? POS_W : NODE_W) + 1;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;

	typedef logic [NODE_W-1:0] node_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_CHECK,
		CMD_RD_FREE,
		CMD_RD_HEAD,
		CMD_WALK,
		CMD_LINK_NEW,
		CMD_RD_NODE,
		CMD_UNLINK,
		CMD_COMMIT,
		CMD_LOAD
	} cmd_t;

	typedef struct packed {
		logic is_delete;
		logic err;
		logic steps_zero;
		logic slot_free;
	} sts_t;

	// head and last node end their chains, the rest chain upward
	function automatic node_t link_init(node_t idx);
		if (idx == '0 || idx == node_t'(NODES - 1)) begin
			return '0;
		end
		return idx + node_t'(1);
	endfunction

endpackage

FILE: hw/rtl/sll_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one list operation item.
// ----------------------------------------------------------------------------
interface sll_in_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [sll_pkg::POS_W-1:0]     position;
	logic [sll_pkg::DATA_W-1:0]    item_data;

	modport source (output valid, kind, position, item_data, input ready);
	modport sink   (input valid, kind, position, item_data, output ready);
endinterface

FILE: hw/rtl/sll_out_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface sll_out_if;
	logic                          valid;
	logic                          ready;
	logic [sll_pkg::DATA_W-1:0]    removed_data;
	logic [sll_pkg::STATUS_W-1:0]  status;
	logic [sll_pkg::LEN_W-1:0]     length;

	modport source (output valid, removed_data, status, length, input ready);
	modport sink   (input valid, removed_data, status, length, output ready);
endinterface

FILE: hw/rtl/static_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Static linked list engine
// Singly linked list with free list in a fixed node store.
// ----------------------------------------------------------------------------
// req carries kind (insert or delete), a 1-based position and a data byte;
// rsp returns one item per request: removed byte, status and list length.
// Items are handled one at a time. req.ready is high only while the block is
// idle; an accepted item walks position-1 links through the link store, one
// store read per cycle, and then updates two links. A rejected item (full
// list or bad position) skips the walk and the link updates.
// The result sits in an output register; if rsp.ready is low the block holds
// it and stalls before loading the next result, so a stalled receiver stops
// the block after at most one further item is taken.
// Reset empties the list, chains nodes 1 and up as the free list and drops
// any pending result; it takes effect at once, with no clearing pass.
// ----------------------------------------------------------------------------
module static_linked_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	sll_in_if.sink      req,
	sll_out_if.source   rsp
);

	sll_pkg::cmd_t cmd;
	sll_pkg::sts_t sts;

	sll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sll_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_kind      (req.kind),
		.in_position  (req.position),
		.in_item_data (req.item_data),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.removed_data (rsp.removed_data),
		.status       (rsp.status),
		.length       (rsp.length)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("item accepted while another is in flight");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != sll_pkg::ST_DONE) |-> (rsp.removed_data == '0))
		else $error("rejected item returned data");

	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> !$past(req.ready))
		else $error("result raised without item in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == sll_pkg::ST_DONE || rsp.status == sll_pkg::ST_NO_FREE ||
			rsp.status == sll_pkg::ST_BAD_POS))
		else $error("undefined status code");

endmodule

FILE: hw/rtl/sll_ctrl.sv
// ----------------------------------------------------------------------------
// Static linked list controller
// Sequences capture, check, link walk, link updates and result load; one command per cycle.
// ----------------------------------------------------------------------------
module sll_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  sll_pkg::sts_t  sts,
	output sll_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_RD_FREE,
		S_RD_HEAD,
		S_WALK,
		S_UNLINK,
		S_COMMIT,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = sll_pkg::CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd     = sll_pkg::CMD_CAPTURE;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd = sll_pkg::CMD_CHECK;
				if (sts.err) begin
					state_d = S_FINISH;
				end else if (sts.is_delete) begin
					state_d = S_RD_HEAD;
				end else begin
					state_d = S_RD_FREE;
				end
			end
			S_RD_FREE: begin
				cmd     = sll_pkg::CMD_RD_FREE;
				state_d = S_RD_HEAD;
			end
			S_RD_HEAD: begin
				cmd     = sll_pkg::CMD_RD_HEAD;
				state_d = S_WALK;
			end
			S_WALK: begin
				if (!sts.steps_zero) begin
					cmd = sll_pkg::CMD_WALK;
				end else if (sts.is_delete) begin
					cmd     = sll_pkg::CMD_RD_NODE;
					state_d = S_UNLINK;
				end else begin
					cmd     = sll_pkg::CMD_LINK_NEW;
					state_d = S_COMMIT;
				end
			end
			S_UNLINK: begin
				cmd     = sll_pkg::CMD_UNLINK;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd     = sll_pkg::CMD_COMMIT;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.slot_free) begin
					cmd     = sll_pkg::CMD_LOAD;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/sll_dpath.sv
// ----------------------------------------------------------------------------
// Static linked list datapath
// Link and value stores, free head, element count, walk cursor, result reg.
// ----------------------------------------------------------------------------
module sll_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sll_pkg::cmd_t                  cmd,
	output sll_pkg::sts_t                  sts,
	input  logic                           in_kind,
	input  logic [sll_pkg::POS_W-1:0]      in_position,
	input  logic [sll_pkg::DATA_W-1:0]     in_item_data,
	input  logic                           rsp_ready,
	output logic                           rsp_valid,
	output logic [sll_pkg::DATA_W-1:0]     removed_data,
	output logic [sll_pkg::STATUS_W-1:0]   status,
	output logic [sll_pkg::LEN_W-1:0]      length
);

	localparam int CW = sll_pkg::CMP_W;
	localparam logic [sll_pkg::POS_W-1:0] POS_ONE = sll_pkg::POS_W'(1);

	// stores
	sll_pkg::node_t                link_mem  [sll_pkg::NODES];
	logic [sll_pkg::DATA_W-1:0]    value_mem [sll_pkg::NODES];
	logic [sll_pkg::NODES-1:0]     link_vld_q;

	// control state
	sll_pkg::node_t                free_head_q;
	sll_pkg::node_t                count_q;
	logic                          rsp_valid_q;

	// item payload
	logic                          kind_q;
	logic [sll_pkg::POS_W-1:0]     pos_q;
	logic [sll_pkg::DATA_W-1:0]    data_q;
	sll_pkg::node_t                steps_q;
	sll_pkg::node_t                pred_q;
	sll_pkg::node_t                node_q;
	sll_pkg::node_t                free_next_q;
	sll_pkg::node_t                link_rd_q;
	logic [sll_pkg::DATA_W-1:0]    value_rd_q;
	logic [sll_pkg::STATUS_W-1:0]  status_q;
	logic [sll_pkg::DATA_W-1:0]    removed_q;
	logic [sll_pkg::DATA_W-1:0]    rsp_removed_q;
	logic [sll_pkg::STATUS_W-1:0]  rsp_status_q;
	logic [sll_pkg::LEN_W-1:0]     rsp_length_q;

	logic                          rd_en;
	sll_pkg::node_t                rd_addr;
	logic                          wr_en;
	sll_pkg::node_t                wr_addr;
	sll_pkg::node_t                wr_data;
	logic [CW-1:0]                 pos_ext;
	logic [CW-1:0]                 cnt_ext;
	logic                          bad_pos;
	logic [sll_pkg::STATUS_W-1:0]  check_code;

	// admission checks; full list wins over a bad position
	assign pos_ext = CW'(pos_q);
	assign cnt_ext = CW'(count_q);
	assign bad_pos = (pos_q == '0) ||
		((kind_q == sll_pkg::KIND_INSERT) ? (pos_ext > cnt_ext + CW'(1)) : (pos_ext > cnt_ext));

	always_comb begin
		if (kind_q == sll_pkg::KIND_INSERT && free_head_q == '0) begin
			check_code = sll_pkg::ST_NO_FREE;
		end else if (bad_pos) begin
			check_code = sll_pkg::ST_BAD_POS;
		end else begin
			check_code = sll_pkg::ST_DONE;
		end
	end

	assign sts.is_delete  = (kind_q == sll_pkg::KIND_DELETE);
	assign sts.err        = (check_code != sll_pkg::ST_DONE);
	assign sts.steps_zero = (steps_q == '0);
	assign sts.slot_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (cmd)
			sll_pkg::CMD_RD_FREE: begin
				rd_en   = 1'b1;
				rd_addr = free_head_q;
			end
			sll_pkg::CMD_RD_HEAD: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			sll_pkg::CMD_WALK, sll_pkg::CMD_RD_NODE: begin
				rd_en   = 1'b1;
				rd_addr = link_rd_q;
			end
			sll_pkg::CMD_LINK_NEW: begin
				wr_en   = 1'b1;
				wr_addr = node_q;
				wr_data = link_rd_q;
			end
			sll_pkg::CMD_UNLINK: begin
				wr_en   = 1'b1;
				wr_addr = pred_q;
				wr_data = link_rd_q;
			end
			sll_pkg::CMD_COMMIT: begin
				wr_en = 1'b1;
				if (kind_q == sll_pkg::KIND_INSERT) begin
					wr_addr = pred_q;
					wr_data = node_q;
				end else begin
					wr_addr = node_q;
					wr_data = free_head_q;
				end
			end
			default: begin
			end
		endcase
	end

	// link store, registered read; unwritten entries read their reset link
	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			link_rd_q <= link_vld_q[rd_addr] ? link_mem[rd_addr] : sll_pkg::link_init(rd_addr);
		end
	end

	// value store
	always_ff @(posedge clk) begin
		if (cmd == sll_pkg::CMD_RD_FREE) begin
			value_mem[free_head_q] <= data_q;
		end
		if (cmd == sll_pkg::CMD_RD_NODE) begin
			value_rd_q <= value_mem[link_rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q  <= '0;
			free_head_q <= sll_pkg::node_t'(1);
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				link_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd == sll_pkg::CMD_COMMIT) begin
				if (kind_q == sll_pkg::KIND_INSERT) begin
					free_head_q <= free_next_q;
					count_q     <= count_q + sll_pkg::node_t'(1);
				end else begin
					free_head_q <= node_q;
					count_q     <= count_q - sll_pkg::node_t'(1);
				end
			end
			if (cmd == sll_pkg::CMD_LOAD) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			sll_pkg::CMD_CAPTURE: begin
				kind_q    <= in_kind;
				pos_q     <= in_position;
				data_q    <= in_item_data;
				removed_q <= '0;
			end
			sll_pkg::CMD_CHECK: begin
				status_q <= check_code;
				steps_q  <= sll_pkg::node_t'(pos_q - POS_ONE);
			end
			sll_pkg::CMD_RD_FREE: begin
				node_q <= free_head_q;
			end
			sll_pkg::CMD_RD_HEAD: begin
				pred_q      <= '0;
				free_next_q <= link_rd_q;
			end
			sll_pkg::CMD_WALK: begin
				pred_q  <= link_rd_q;
				steps_q <= steps_q - sll_pkg::node_t'(1);
			end
			sll_pkg::CMD_RD_NODE: begin
				node_q <= link_rd_q;
			end
			sll_pkg::CMD_COMMIT: begin
				if (kind_q == sll_pkg::KIND_DELETE) begin
					removed_q <= value_rd_q;
				end
			end
			sll_pkg::CMD_LOAD: begin
				rsp_removed_q <= removed_q;
				rsp_status_q  <= status_q;
				rsp_length_q  <= sll_pkg::LEN_W'(count_q);
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid    = rsp_valid_q;
	assign removed_data = rsp_removed_q;
	assign status       = rsp_status_q;
	assign length       = rsp_length_q;

endmodule
